// ===== hdl/unsd_pkg.sv =====
`default_nettype none

package unsd_pkg;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_UBX_BYTE  = 3'd1,
        EV_UBX_GOOD  = 3'd2,
        EV_UBX_BAD   = 3'd3,
        EV_UBX_DROP  = 3'd4,
        EV_NMEA_GOOD = 3'd5,
        EV_NMEA_BAD  = 3'd6,
        EV_NMEA_OVER = 3'd7
    } event_t;

    // First UBX sync byte; also aborts an open NMEA line
    localparam logic [7:0] SYNC_ONE = 8'hB5;

    // One result item
    typedef struct packed {
        event_t      event_res;
        logic [7:0]  payload_byte;
        logic [6:0]  payload_index;
        logic [7:0]  frame_class;
        logic [7:0]  frame_ident;
        logic [7:0]  frame_length;
        logic        is_nav_pvt;
        logic [1:0]  sentence_kind;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/ubx_nmea_stream_deframer.sv =====
// Receiver byte stream deframer for mixed UBX binary frames and NMEA lines.
// Slave channel: one received byte per transaction on s_axis_tdata.
// Master channel: exactly one result transaction per accepted byte. The
// event code on m_axis_tuser tells what it carries: nothing, a forwarded
// UBX payload byte with its index, a finished UBX frame (good, bad sum or
// dropped as too long), or a finished NMEA sentence (good with its kind,
// bad checksum or malformed line, or overflowed line).
// Latency: the result for a byte is valid in the cycle after the byte is
// accepted. Throughput: one byte per cycle while results are taken; the frame parser
// and line parser each update a handful of small registers per byte, and
// the result register is the only stage.
// Stall: while a result waits and m_axis_tready is low, s_axis_tready
// drops; when the result is taken, a new byte is accepted in the same
// cycle, so there are no bubbles.
// Reset: rst_n clears both parsers to idle and empties the result
// register; no clearing pass is needed, the block is ready as soon as
// reset is released.
`default_nettype none

module ubx_nmea_stream_deframer
    import unsd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 128,
    parameter int MAX_LINE    = 100
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] payload_byte, [14:8] payload_index, [22:15] frame_class,
    // [30:23] frame_ident, [38:31] frame_length, [39] is_nav_pvt,
    // [41:40] sentence_kind, [47:42] zero
    output logic [47:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser    // [2:0] event_res
);

    logic in_accept;
    logic ubx_idle;
    res_t ubx_res;
    res_t nmea_res;
    res_t res_next;

    res_t res_reg;
    logic valid_reg;

    // Accept whenever the result register is empty or is drained this cycle
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // UBX frame parser sees every byte; bytes inside a frame belong to it
    unsd_ubx #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ubx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_accept),
        .rx_byte (s_axis_tdata),
        .idle    (ubx_idle),
        .res     (ubx_res)
    );

    // NMEA line parser only advances while no UBX frame is open; a first
    // sync byte seen here abandons any open line
    unsd_nmea #(
        .MAX_LINE (MAX_LINE)
    ) u_nmea (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_accept && ubx_idle),
        .rx_byte (s_axis_tdata),
        .res     (nmea_res)
    );

    // In idle the frame parser never reports, so the line result stands
    assign res_next = ubx_idle ? nmea_res : ubx_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_accept)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    // Payload holds until the next accepted byte
    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.event_res;
    assign m_axis_tdata  = {6'd0,
                            res_reg.sentence_kind,
                            res_reg.is_nav_pvt,
                            res_reg.frame_length,
                            res_reg.frame_ident,
                            res_reg.frame_class,
                            res_reg.payload_index,
                            res_reg.payload_byte};

`ifndef SYNTHESIS
    // Every accepted byte leaves a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    // The line parser stays quiet while a UBX frame owns the stream
    a_nmea_quiet_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !ubx_idle |-> (nmea_res.event_res == EV_NONE))
        else $error("line result while a frame is open");

    // Sentence kind is only set on a good sentence
    a_kind_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != EV_NMEA_GOOD)) |->
            (m_axis_tdata[41:40] == 2'd0))
        else $error("sentence kind outside a good sentence");

    // NAV-PVT flag is only set on a good frame
    a_pvt_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != EV_UBX_GOOD)) |->
            (m_axis_tdata[39] == 1'b0))
        else $error("nav-pvt flag outside a good frame");
`endif

endmodule

`default_nettype wire

// ===== hdl/unsd_ubx.sv =====
`default_nettype none

module unsd_ubx
    import unsd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output logic            idle,
    output res_t            res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] SYNC_TWO    = 8'h62;
    localparam logic [7:0] NAV_CLASS   = 8'h01;
    localparam logic [7:0] PVT_IDENT   = 8'h07;
    localparam logic [15:0] PVT_MIN_LEN = 16'd92;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_IDENT   = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         class_reg, class_next;
    logic [7:0]         ident_reg, ident_next;
    logic [15:0]        length_reg, length_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         sum_a_reg, sum_a_next;
    logic [7:0]         sum_b_reg, sum_b_next;
    logic [7:0]         rx_sum_a_reg, rx_sum_a_next;

    logic [7:0]         sum_a_add;
    logic [7:0]         sum_b_add;
    logic [15:0]        length_full;
    logic [CNT_W-1:0]   count_inc;

    assign sum_a_add   = sum_a_reg + rx_byte;
    assign sum_b_add   = sum_b_reg + sum_a_add;
    assign length_full = {rx_byte, length_reg[7:0]};
    assign count_inc   = count_reg + CNT_W'(1);
    assign idle        = (phase_reg == PH_IDLE);

    always_comb
    begin
        phase_next    = phase_reg;
        class_next    = class_reg;
        ident_next    = ident_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        rx_sum_a_next = rx_sum_a_reg;
        res           = '0;
        if (step)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == SYNC_ONE)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == SYNC_TWO) ? PH_CLASS : PH_IDLE;
                end
                PH_CLASS:
                begin
                    class_next = rx_byte;
                    sum_a_next = rx_byte;
                    sum_b_next = rx_byte;
                    phase_next = PH_IDENT;
                end
                PH_IDENT:
                begin
                    ident_next = rx_byte;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {8'h00, rx_byte};
                    sum_a_next  = sum_a_add;
                    sum_b_next  = sum_b_add;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = length_full;
                    sum_a_next  = sum_a_add;
                    sum_b_next  = sum_b_add;
                    count_next  = '0;
                    if (length_full == 16'd0)
                        phase_next = PH_CK_A;
                    else if (length_full <= 16'(MAX_PAYLOAD))
                        phase_next = PH_PAYLOAD;
                    else
                    begin
                        // Too long: drop the frame, report class and id only
                        phase_next      = PH_IDLE;
                        res.event_res   = EV_UBX_DROP;
                        res.frame_class = class_reg;
                        res.frame_ident = ident_reg;
                    end
                end
                PH_PAYLOAD:
                begin
                    res.event_res     = EV_UBX_BYTE;
                    res.payload_byte  = rx_byte;
                    res.payload_index = count_reg[6:0];
                    sum_a_next        = sum_a_add;
                    sum_b_next        = sum_b_add;
                    count_next        = count_inc;
                    if (16'(count_inc) >= length_reg)
                        phase_next = PH_CK_A;
                end
                PH_CK_A:
                begin
                    rx_sum_a_next = rx_byte;
                    phase_next    = PH_CK_B;
                end
                PH_CK_B:
                begin
                    res.frame_class  = class_reg;
                    res.frame_ident  = ident_reg;
                    res.frame_length = length_reg[7:0];
                    if (rx_sum_a_reg == sum_a_reg && rx_byte == sum_b_reg)
                    begin
                        res.event_res  = EV_UBX_GOOD;
                        res.is_nav_pvt = (class_reg == NAV_CLASS) &&
                                         (ident_reg == PVT_IDENT) &&
                                         (length_reg >= PVT_MIN_LEN);
                    end
                    else
                        res.event_res = EV_UBX_BAD;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            class_reg    <= '0;
            ident_reg    <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            rx_sum_a_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            class_reg    <= class_next;
            ident_reg    <= ident_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            rx_sum_a_reg <= rx_sum_a_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/unsd_nmea.sv =====
`default_nettype none

module unsd_nmea
    import unsd_pkg::*;
#(
    parameter int MAX_LINE = 100
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output res_t            res
);

    localparam int LC_W = $clog2(MAX_LINE);

    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [23:0] TYPE_GGA  = 24'h474741;
    localparam logic [23:0] TYPE_RMC  = 24'h524D43;

    localparam logic [1:0]  KIND_OTHER = 2'd0;
    localparam logic [1:0]  KIND_GGA   = 2'd1;
    localparam logic [1:0]  KIND_RMC   = 2'd2;
    localparam logic [1:0]  KIND_SHORT = 2'd3;

    // {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    logic            active_reg, active_next;
    logic [LC_W-1:0] count_reg, count_next;
    logic [7:0]      xor_reg, xor_next;
    logic [LC_W-1:0] star_reg, star_next;
    logic [7:0]      hex_reg, hex_next;
    logic            hex_stop_reg, hex_stop_next;
    logic [23:0]     type_reg, type_next;
    logic [2:0]      body_len_reg, body_len_next;
    logic            body_end_reg, body_end_next;

    logic [4:0]      digit;
    logic            line_ok;

    assign digit   = hex_digit(rx_byte);
    assign line_ok = (count_reg >= LC_W'(4)) && (star_reg != '0) &&
                     ({1'b0, star_reg} + (LC_W+1)'(2) < {1'b0, count_reg}) &&
                     (hex_reg == xor_reg);

    always_comb
    begin
        active_next   = active_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        star_next     = star_reg;
        hex_next      = hex_reg;
        hex_stop_next = hex_stop_reg;
        type_next     = type_reg;
        body_len_next = body_len_reg;
        body_end_next = body_end_reg;
        res           = '0;
        if (step)
        begin
            if (rx_byte == SYNC_ONE || rx_byte == CH_DOLLAR ||
                (active_reg && (rx_byte == CH_CR || rx_byte == CH_LF ||
                                count_reg >= LC_W'(MAX_LINE - 1))))
            begin
                // Close or restart the line, clear all line state
                count_next    = '0;
                xor_next      = '0;
                star_next     = '0;
                hex_next      = '0;
                hex_stop_next = 1'b0;
                type_next     = '0;
                body_len_next = '0;
                body_end_next = 1'b0;
                active_next   = 1'b0;
                if (rx_byte == CH_DOLLAR)
                begin
                    active_next = 1'b1;
                    count_next  = LC_W'(1);
                end
                else if (rx_byte == SYNC_ONE)
                    active_next = 1'b0;
                else if (rx_byte == CH_CR || rx_byte == CH_LF)
                begin
                    if (line_ok)
                    begin
                        res.event_res = EV_NMEA_GOOD;
                        if (body_len_reg < 3'd5)
                            res.sentence_kind = KIND_SHORT;
                        else if (type_reg == TYPE_GGA)
                            res.sentence_kind = KIND_GGA;
                        else if (type_reg == TYPE_RMC)
                            res.sentence_kind = KIND_RMC;
                        else
                            res.sentence_kind = KIND_OTHER;
                    end
                    else
                        res.event_res = EV_NMEA_BAD;
                end
                else
                    res.event_res = EV_NMEA_OVER;
            end
            else if (active_reg)
            begin
                if (star_reg == '0)
                begin
                    if (rx_byte == CH_STAR)
                        star_next = count_reg;
                    else
                        xor_next = xor_reg ^ rx_byte;
                end
                else if (!hex_stop_reg)
                begin
                    if (!digit[4])
                        hex_stop_next = 1'b1;
                    else
                        hex_next = {hex_reg[3:0], digit[3:0]};
                end
                if (!body_end_reg)
                begin
                    if (rx_byte == CH_STAR || rx_byte == 8'h00)
                        body_end_next = 1'b1;
                    else if (body_len_reg < 3'd5)
                        body_len_next = body_len_reg + 3'd1;
                end
                if (count_reg >= LC_W'(3) && count_reg <= LC_W'(5))
                    type_next = {type_reg[15:0], rx_byte};
                count_next = count_reg + LC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            count_reg    <= '0;
            xor_reg      <= '0;
            star_reg     <= '0;
            hex_reg      <= '0;
            hex_stop_reg <= 1'b0;
            type_reg     <= '0;
            body_len_reg <= '0;
            body_end_reg <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            star_reg     <= star_next;
            hex_reg      <= hex_next;
            hex_stop_reg <= hex_stop_next;
            type_reg     <= type_next;
            body_len_reg <= body_len_next;
            body_end_reg <= body_end_next;
        end
    end

endmodule

`default_nettype wire
